// ===== hdl/rmq_pkg.sv =====
// Shared constants for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_W = 17;

  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;
  localparam logic [1:0] PIV_W = 2'd3;

endpackage

// ===== hdl/rmq_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, with sideband.
module rmq_sqrt #(
  parameter int NW   = 32,
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [NW-1:0]   rad,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_valid,
  output logic [NW/2-1:0] root,
  output logic [SB_W-1:0] sb_out
);

  localparam int RW   = NW / 2;
  localparam int REMW = RW + 2;
  localparam int SHW  = RW + 4;

  logic [REMW-1:0] rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [NW-1:0]   rad_q  [RW+1];
  logic [SB_W-1:0] sb_q   [RW+1];
  logic [RW:0]     vld;

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad;
  assign sb_q[0]   = sb_in;
  assign vld[0]    = in_valid;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SHW-1:0] rem_sh;
    logic [SHW-1:0] trial;
    logic           ge;

    assign rem_sh = {rem_q[k], rad_q[k][NW-1 -: 2]};
    assign trial  = {2'b00, root_q[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k+1]  <= ge ? REMW'(rem_sh - trial) : rem_sh[REMW-1:0];
      root_q[k+1] <= {root_q[k][RW-2:0], ge};
      rad_q[k+1]  <= {rad_q[k][NW-3:0], 2'b00};
      sb_q[k+1]   <= sb_q[k];
    end
  end

  assign out_valid = vld[RW];
  assign root      = root_q[RW];
  assign sb_out    = sb_q[RW];

endmodule

// ===== hdl/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rmq_div #(
  parameter int DW = 32,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          out_valid,
  output logic [DW-1:0] quotient
);

  logic [VW-1:0] rem_q [DW+1];
  logic [DW-1:0] acc_q [DW+1];
  logic [VW-1:0] dvs_q [DW+1];
  logic [DW:0]   vld;

  assign rem_q[0] = '0;
  assign acc_q[0] = dividend;
  assign dvs_q[0] = divisor;
  assign vld[0]   = in_valid;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_q[k], acc_q[k][DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_q[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k+1] <= ge ? VW'(rem_sh - {1'b0, dvs_q[k]}) : rem_sh[VW-1:0];
      acc_q[k+1] <= {acc_q[k][DW-2:0], ge};
      dvs_q[k+1] <= dvs_q[k];
    end
  end

  assign out_valid = vld[DW];
  assign quotient  = acc_q[DW];

endmodule

// ===== hdl/rotation_matrix_to_quaternion_top.sv =====
// Throughput: one matrix per cycle; busy is high only during reset.
// The square root pipeline (one root bit per stage) and the three dividers
// (one quotient bit per stage) set the depth.
// Reset: synchronous, clears all valid bits; results must be taken as shown.
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m00,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m01,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m02,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m10,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m11,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m12,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m20,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m21,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m22,
  output logic                               done,
  output logic signed [rmq_pkg::DATA_W-1:0]  qx,
  output logic signed [rmq_pkg::DATA_W-1:0]  qy,
  output logic signed [rmq_pkg::DATA_W-1:0]  qz,
  output logic signed [rmq_pkg::DATA_W-1:0]  qw
);

  localparam int NUM_W = rmq_pkg::NUM_W;
  localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RS_W  = RAD_W + 1;
  localparam int NW    = ((RAD_W + FRAC_BITS + 1) / 2) * 2;
  localparam int SQ_W  = NW / 2;
  localparam int DV_W  = NUM_W + FRAC_BITS + 1;
  localparam int VS_W  = SQ_W + 1;
  localparam int SB_W  = 2 + 3 + 3 * NUM_W;
  localparam int DL_W  = 2 + 3 + SQ_W + 1;
  localparam int LAT   = 3 + SQ_W + DV_W;
  localparam int CAP_P = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int CAP_N = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);
  localparam logic [DV_W-1:0] CAP_PV = DV_W'(CAP_P);
  localparam logic [DV_W-1:0] CAP_NV = DV_W'(CAP_N);
  localparam logic [RS_W-1:0] ONE_R = RS_W'(1) << FRAC_BITS;

  // ---------------- stage A: branch, pivot, radicand, numerators
  logic signed [RS_W-1:0] e00, e11, e22, tr, rs;
  logic signed [NUM_W:0]  a01, a02, a10, a12, a20, a21;
  logic signed [NUM_W:0]  n [3];
  logic [1:0]             pid;
  logic                   accept;

  assign busy   = rst;
  assign accept = start && !busy;

  assign e00 = RS_W'(m00);
  assign e11 = RS_W'(m11);
  assign e22 = RS_W'(m22);
  assign a01 = (NUM_W+1)'(m01);
  assign a02 = (NUM_W+1)'(m02);
  assign a10 = (NUM_W+1)'(m10);
  assign a12 = (NUM_W+1)'(m12);
  assign a20 = (NUM_W+1)'(m20);
  assign a21 = (NUM_W+1)'(m21);
  assign tr  = e00 + e11 + e22;

  always_comb begin
    if (tr > 0) begin
      pid = rmq_pkg::PIV_W;
    end else if (m00 < m11) begin
      pid = (m11 < m22) ? rmq_pkg::PIV_Z : rmq_pkg::PIV_Y;
    end else begin
      pid = (m00 < m22) ? rmq_pkg::PIV_Z : rmq_pkg::PIV_X;
    end
  end

  // Numerators go to dividers in order of the non-pivot components.
  always_comb begin
    unique case (pid)
      rmq_pkg::PIV_X: begin
        rs   = e00 - e11 - e22 + $signed(ONE_R);
        n[0] = a10 + a01;
        n[1] = a20 + a02;
        n[2] = a21 - a12;
      end
      rmq_pkg::PIV_Y: begin
        rs   = e11 - e22 - e00 + $signed(ONE_R);
        n[0] = a01 + a10;
        n[1] = a21 + a12;
        n[2] = a02 - a20;
      end
      rmq_pkg::PIV_Z: begin
        rs   = e22 - e00 - e11 + $signed(ONE_R);
        n[0] = a02 + a20;
        n[1] = a12 + a21;
        n[2] = a10 - a01;
      end
      default: begin
        rs   = tr + $signed(ONE_R);
        n[0] = a21 - a12;
        n[1] = a02 - a20;
        n[2] = a10 - a01;
      end
    endcase
  end

  logic             a_vld;
  logic [RAD_W-1:0] a_rad;
  logic [1:0]       a_pid;
  logic [2:0]       a_sgn;
  logic [NUM_W-1:0] a_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    // Drop a radicand that is not positive: all components become zero.
    a_rad <= (rs > 0) ? rs[RAD_W-1:0] : '0;
    a_pid <= pid;
    for (int i = 0; i < 3; i++) begin
      a_sgn[i] <= n[i][NUM_W];
      a_mag[i] <= n[i][NUM_W] ? NUM_W'(-n[i]) : n[i][NUM_W-1:0];
    end
  end

  // ---------------- square root
  logic            s_vld;
  logic [SQ_W-1:0] s_root;
  logic [SB_W-1:0] s_sb;
  logic [1:0]      s_pid;
  logic [2:0]      s_sgn;
  logic [NUM_W-1:0] s_mag [3];

  rmq_sqrt #(.NW(NW), .SB_W(SB_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_vld),
    .rad      (NW'({a_rad, {FRAC_BITS{1'b0}}})),
    .sb_in    ({a_pid, a_sgn, a_mag[0], a_mag[1], a_mag[2]}),
    .out_valid(s_vld),
    .root     (s_root),
    .sb_out   (s_sb)
  );

  assign {s_pid, s_sgn, s_mag[0], s_mag[1], s_mag[2]} = s_sb;

  // ---------------- stage B: pivot value and division operands
  logic            b_vld;
  logic [DV_W-1:0] b_dvd [3];
  logic [VS_W-1:0] b_dvs;
  logic [DL_W-1:0] dly [DV_W+1];
  logic [SQ_W:0]   s_inc;

  assign s_inc = {1'b0, s_root} + (SQ_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b_dvd[i] <= DV_W'({s_mag[i], {FRAC_BITS{1'b0}}}) + DV_W'(s_root);
    end
    b_dvs  <= {s_root, 1'b0};
    dly[0] <= {s_pid, s_sgn, s_inc[SQ_W:1], (s_root == '0)};
  end

  // ---------------- dividers, sideband held alongside
  logic            d_vld;
  logic [DV_W-1:0] quo [3];

  rmq_div #(.DW(DV_W), .VW(VS_W)) u_div0 (
    .clk(clk), .rst(rst), .in_valid(b_vld), .dividend(b_dvd[0]), .divisor(b_dvs),
    .out_valid(d_vld), .quotient(quo[0])
  );
  rmq_div #(.DW(DV_W), .VW(VS_W)) u_div1 (
    .clk(clk), .rst(rst), .in_valid(b_vld), .dividend(b_dvd[1]), .divisor(b_dvs),
    .out_valid(), .quotient(quo[1])
  );
  rmq_div #(.DW(DV_W), .VW(VS_W)) u_div2 (
    .clk(clk), .rst(rst), .in_valid(b_vld), .dividend(b_dvd[2]), .divisor(b_dvs),
    .out_valid(), .quotient(quo[2])
  );

  for (genvar k = 0; k < DV_W; k++) begin : g_dly
    always_ff @(posedge clk) begin
      dly[k+1] <= dly[k];
    end
  end

  // ---------------- output stage: place components and saturate
  logic [1:0]            o_pid;
  logic [2:0]            o_sgn;
  logic [SQ_W-1:0]       o_pv;
  logic                  o_zero;
  logic [rmq_pkg::DATA_W-1:0] q_next [4];

  assign {o_pid, o_sgn, o_pv, o_zero} = dly[DV_W];

  always_comb begin
    logic [1:0]      idx;
    logic [DV_W-1:0] mag;
    logic            neg;
    logic [NUM_W-1:0] val;
    for (int t = 0; t < 4; t++) begin
      idx = (2'(t) < o_pid) ? 2'(t) : 2'(t - 1);
      if (2'(t) == o_pid) begin
        mag = DV_W'(o_pv);
        neg = 1'b0;
      end else begin
        mag = quo[idx];
        neg = o_sgn[idx];
      end
      if (o_zero) begin
        mag = '0;
      end
      if (neg && mag > CAP_NV) begin
        mag = CAP_NV;
      end else if (!neg && mag > CAP_PV) begin
        mag = CAP_PV;
      end
      val       = neg ? NUM_W'(-mag[NUM_W-1:0]) : mag[NUM_W-1:0];
      q_next[t] = val[rmq_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    qx <= q_next[0];
    qy <= q_next[1];
    qz <= q_next[2];
    qw <= q_next[3];
  end

  // ---------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted transaction did not complete after pipeline latency");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(qx) >= -CAP_N && $signed(qx) <= CAP_P
              && $signed(qy) >= -CAP_N && $signed(qy) <= CAP_P
              && $signed(qz) >= -CAP_N && $signed(qz) <= CAP_P
              && $signed(qw) >= -CAP_N && $signed(qw) <= CAP_P))
    else $error("quaternion component outside saturation range");

endmodule
